// ----- hdl/pba_pkg.sv -----
// ----------------------------------------------------------------------------
// pba_pkg
// Shared sizes, types, codes and helpers of the page bitmap allocator.
// ----------------------------------------------------------------------------
package pba_pkg;

   // bitmap geometry
   localparam int MAP_WORDS    = 1024;
   localparam int WORD_BITS    = 64;
   localparam int BIT_W        = 6;
   localparam int WORD_AW      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int SUM_WORDS    = (MAP_WORDS + WORD_BITS - 1) / WORD_BITS;
   localparam int SUM_AW       = (SUM_WORDS > 1) ? $clog2(SUM_WORDS) : 1;
   localparam int FRAME_W      = WORD_AW + BIT_W;
   localparam int TOTAL_FRAMES = MAP_WORDS * WORD_BITS;

   // field widths
   localparam int FRAME_SHIFT = 21;
   localparam int ADDR_W      = 37;
   localparam int LEN_W       = 38;
   localparam int LIMIT_W     = 38;
   localparam int AFN_W       = ADDR_W - FRAME_SHIFT;
   localparam int CNT_W       = LEN_W - FRAME_SHIFT + 1;
   localparam int SPAN_A      = ((AFN_W > CNT_W) ? AFN_W : CNT_W) + 1;
   localparam int SPAN_W      = (SPAN_A > FRAME_W + 1) ? SPAN_A : FRAME_W + 1;
   localparam int FADDR_W     = FRAME_W + FRAME_SHIFT;
   localparam int CMP_W       = (FADDR_W > LIMIT_W) ? FADDR_W : LIMIT_W;

   // register port
   localparam int CSR_AW    = 4;
   localparam int CSR_DW    = 64;
   localparam int REG_SHIFT = 3;

   typedef logic [WORD_BITS-1:0] map_word_type;
   typedef logic [WORD_AW-1:0]   word_idx_type;
   typedef logic [SUM_AW-1:0]    sum_idx_type;
   typedef logic [BIT_W-1:0]     bit_idx_type;
   typedef logic [SPAN_W-1:0]    span_type;
   typedef logic [ADDR_W-1:0]    addr_type;
   typedef logic [CMP_W-1:0]     cmp_type;
   typedef logic [CSR_DW-1:0]    csr_data_type;

   localparam span_type TOTAL_SPAN = span_type'(TOTAL_FRAMES);
   localparam logic [LEN_W:0] FRAME_ROUND = (LEN_W + 1)'((64'd1 << FRAME_SHIFT) - 64'd1);

   typedef enum logic [1:0] {
      OP_RESERVE = 2'd0,
      OP_ALLOC   = 2'd1,
      OP_RELEASE = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_ZERO_LEN = 2'd1,
      ST_LIMIT    = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   typedef enum logic [0:0] {
      REG_MEMORY_LIMIT = 1'b0
   } reg_index_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_RES_MOD,
      S_ALC_SUM,
      S_ALC_MAP,
      S_REL_MOD,
      S_SUM_UPD
   } state_type;

   typedef struct packed {
      logic         we;
      word_idx_type waddr;
      map_word_type wdata;
      word_idx_type raddr;
   } map_req_type;

   typedef struct packed {
      logic         we;
      sum_idx_type  waddr;
      map_word_type wdata;
      sum_idx_type  raddr;
   } sum_req_type;

   // index of the lowest clear bit, zero when none
   function automatic bit_idx_type first_zero(input map_word_type w);
      bit_idx_type idx;
      idx = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (!w[i]) idx = bit_idx_type'(i);
      end
      return idx;
   endfunction

endpackage

// ----- hdl/page_bitmap_allocator.sv -----
// ----------------------------------------------------------------------------
// page_bitmap_allocator
// Bitmap allocator of 2 MiB physical frames, one bit per frame.
//
// Requests enter on start/req_* and are taken when start is high and busy is
// low. Opcodes: reserve a byte range, allocate the lowest free frame, release
// one frame. Every request yields one result: rsp_valid pulses for one cycle
// with rsp_status and rsp_frame_address; the receiver cannot stall it.
// Immediate answers (zero length, map full, frame past the map, unused
// opcode) come straight from idle. Allocate reads the summary word, then the
// bitmap word, and writes it back; release reads and writes the word; reserve
// does one read-modify-write per bitmap word touched. Each adds a summary
// update for a word full after the write (allocate, reserve) or full before
// it (release). The bitmap RAM read-modify-write loop (one registered read
// per word) and a summary RAM of full words carry these steps. busy drops in
// the result cycle, so the next request can be taken at the edge that ends it.
// After reset the block runs a clearing pass over all MAP_WORDS (1024) words
// that zeroes the bitmap and builds the summary; busy stays high meanwhile.
// memory_limit sits at APB byte address 0; write it only while no request is
// in flight.
// ----------------------------------------------------------------------------
module page_bitmap_allocator (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [1:0]                     req_opcode,
   input  logic [pba_pkg::ADDR_W-1:0]     req_address,
   input  logic [pba_pkg::LEN_W-1:0]      req_length,
   output logic                           rsp_valid,
   output logic [1:0]                     rsp_status,
   output logic [pba_pkg::ADDR_W-1:0]     rsp_frame_address,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [pba_pkg::CSR_AW-1:0]     paddr,
   input  pba_pkg::csr_data_type          pwdata,
   output pba_pkg::csr_data_type          prdata,
   output logic                           pready
);

   logic [pba_pkg::LIMIT_W-1:0] memory_limit;
   pba_pkg::map_req_type        map_req;
   pba_pkg::sum_req_type        sum_req;
   pba_pkg::map_word_type       map_rdata;
   pba_pkg::map_word_type       sum_rdata;

   pba_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .memory_limit (memory_limit)
   );

   pba_ram #(
      .WIDTH (pba_pkg::WORD_BITS),
      .DEPTH (pba_pkg::MAP_WORDS)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (map_req.we),
      .wr_addr (map_req.waddr),
      .wr_data (map_req.wdata),
      .rd_addr (map_req.raddr),
      .rd_data (map_rdata)
   );

   pba_ram #(
      .WIDTH (pba_pkg::WORD_BITS),
      .DEPTH (pba_pkg::SUM_WORDS)
   ) u_sum_ram (
      .clock   (clock),
      .wr_en   (sum_req.we),
      .wr_addr (sum_req.waddr),
      .wr_data (sum_req.wdata),
      .rd_addr (sum_req.raddr),
      .rd_data (sum_rdata)
   );

   pba_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_address       (req_address),
      .req_length        (req_length),
      .memory_limit      (memory_limit),
      .map_rdata         (map_rdata),
      .sum_rdata         (sum_rdata),
      .map_req           (map_req),
      .sum_req           (sum_req),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_frame_address (rsp_frame_address)
   );

endmodule

// ----- hdl/pba_ram.sv -----
// ----------------------------------------------------------------------------
// pba_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pba_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/pba_csr.sv -----
// ----------------------------------------------------------------------------
// pba_csr
// APB register file holding the allocation memory limit.
// ----------------------------------------------------------------------------
module pba_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [pba_pkg::CSR_AW-1:0]     paddr,
   input  pba_pkg::csr_data_type          pwdata,
   output pba_pkg::csr_data_type          prdata,
   output logic                           pready,
   output logic [pba_pkg::LIMIT_W-1:0]    memory_limit
);

   logic [pba_pkg::LIMIT_W-1:0] limit_ff;
   logic [pba_pkg::LIMIT_W-1:0] limit_in;
   logic                        sel_limit;
   logic                        wr_fire;

   assign sel_limit = (paddr[pba_pkg::CSR_AW-1:pba_pkg::REG_SHIFT] == pba_pkg::REG_MEMORY_LIMIT);
   assign wr_fire   = psel && penable && pwrite;

   always_comb begin
      limit_in = limit_ff;
      if (wr_fire && sel_limit) begin
         limit_in = pwdata[pba_pkg::LIMIT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= '0;
      end else begin
         limit_ff <= limit_in;
      end
   end

   assign prdata       = sel_limit ? pba_pkg::csr_data_type'(limit_ff) : '0;
   assign pready       = 1'b1;
   assign memory_limit = limit_ff;

endmodule

// ----- hdl/pba_ctrl.sv -----
// ----------------------------------------------------------------------------
// pba_ctrl
// Request sequencer: read-modify-write of the frame bitmap and of the
// summary map of full words, plus the top-level vector of full summary words.
// ----------------------------------------------------------------------------
module pba_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [1:0]                     req_opcode,
   input  logic [pba_pkg::ADDR_W-1:0]     req_address,
   input  logic [pba_pkg::LEN_W-1:0]      req_length,
   input  logic [pba_pkg::LIMIT_W-1:0]    memory_limit,
   input  pba_pkg::map_word_type          map_rdata,
   input  pba_pkg::map_word_type          sum_rdata,
   output pba_pkg::map_req_type           map_req,
   output pba_pkg::sum_req_type           sum_req,
   output logic                           rsp_valid,
   output logic [1:0]                     rsp_status,
   output logic [pba_pkg::ADDR_W-1:0]     rsp_frame_address
);

   pba_pkg::state_type     state_ff, state_in;
   pba_pkg::word_idx_type  clr_ff, clr_in;
   pba_pkg::word_idx_type  word_ff, word_in;
   pba_pkg::bit_idx_type   lo_ff, lo_in;
   pba_pkg::word_idx_type  last_word_ff, last_word_in;
   pba_pkg::bit_idx_type   last_bit_ff, last_bit_in;
   pba_pkg::sum_idx_type   sidx_ff, sidx_in;
   logic [1:0]             op_ff, op_in;
   logic                   set_ff, set_in;
   logic [pba_pkg::SUM_WORDS-1:0] top_ff, top_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   pba_pkg::status_type    rsp_status_ff, rsp_status_in;
   pba_pkg::addr_type      rsp_addr_ff, rsp_addr_in;

   // request decode
   pba_pkg::span_type      first_span;
   logic [pba_pkg::LEN_W:0] len_round;
   logic [pba_pkg::CNT_W-1:0] count;
   pba_pkg::span_type      end_raw;
   pba_pkg::span_type      end_clamp;
   pba_pkg::span_type      last_span;
   logic                   in_map;
   logic                   top_hit;
   pba_pkg::sum_idx_type   top_idx;

   // per-state datapath
   pba_pkg::bit_idx_type   hi_bit;
   pba_pkg::map_word_type  res_mask;
   pba_pkg::map_word_type  res_word;
   pba_pkg::bit_idx_type   alc_bit;
   pba_pkg::map_word_type  alc_word;
   logic [pba_pkg::FRAME_W-1:0] alc_frame;
   logic [pba_pkg::FADDR_W-1:0] alc_faddr;
   logic                   alc_over;
   pba_pkg::map_word_type  rel_word;
   pba_pkg::sum_idx_type   word_sidx;
   pba_pkg::map_word_type  sum_bit;
   pba_pkg::map_word_type  sum_new;
   pba_pkg::map_word_type  pad_word;
   pba_pkg::word_idx_type  word_next;

   // request decode
   always_comb begin
      first_span = pba_pkg::span_type'(req_address >> pba_pkg::FRAME_SHIFT);
      len_round  = {1'b0, req_length} + pba_pkg::FRAME_ROUND;
      count      = len_round[pba_pkg::LEN_W:pba_pkg::FRAME_SHIFT];
      end_raw    = first_span + pba_pkg::span_type'(count);
      end_clamp  = (end_raw > pba_pkg::TOTAL_SPAN) ? pba_pkg::TOTAL_SPAN : end_raw;
      last_span  = end_clamp - pba_pkg::span_type'(1);
      in_map     = first_span < pba_pkg::TOTAL_SPAN;
   end

   // lowest summary word that still has a free word
   always_comb begin
      top_hit = 1'b0;
      top_idx = '0;
      for (int i = pba_pkg::SUM_WORDS - 1; i >= 0; i--) begin
         if (!top_ff[i]) begin
            top_hit = 1'b1;
            top_idx = pba_pkg::sum_idx_type'(i);
         end
      end
   end

   // summary entries that stand for words past the map read as full
   always_comb begin
      for (int b = 0; b < pba_pkg::WORD_BITS; b++) begin
         pad_word[b] = (32'(clr_ff) * 32'(pba_pkg::WORD_BITS) + 32'(b))
                       >= 32'(pba_pkg::MAP_WORDS);
      end
   end

   always_comb begin
      word_next = word_ff + pba_pkg::word_idx_type'(1);
      word_sidx = pba_pkg::sum_idx_type'(word_ff >> pba_pkg::BIT_W);
      sum_bit   = pba_pkg::map_word_type'(1) << pba_pkg::bit_idx_type'(word_ff);
      sum_new   = set_ff ? (sum_rdata | sum_bit) : (sum_rdata & ~sum_bit);

      hi_bit    = (word_ff == last_word_ff) ? last_bit_ff : pba_pkg::bit_idx_type'('1);
      res_mask  = ({pba_pkg::WORD_BITS{1'b1}} << lo_ff)
                  & ({pba_pkg::WORD_BITS{1'b1}} >> (pba_pkg::bit_idx_type'('1) - hi_bit));
      res_word  = map_rdata | res_mask;

      alc_bit   = pba_pkg::first_zero(map_rdata);
      alc_word  = map_rdata | (pba_pkg::map_word_type'(1) << alc_bit);
      alc_frame = {word_ff, alc_bit};
      alc_faddr = {alc_frame, {pba_pkg::FRAME_SHIFT{1'b0}}};
      alc_over  = pba_pkg::cmp_type'(alc_faddr) >= pba_pkg::cmp_type'(memory_limit);

      rel_word  = map_rdata & ~(pba_pkg::map_word_type'(1) << lo_ff);
   end

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      word_in       = word_ff;
      lo_in         = lo_ff;
      last_word_in  = last_word_ff;
      last_bit_in   = last_bit_ff;
      sidx_in       = sidx_ff;
      op_in         = op_ff;
      set_in        = set_ff;
      top_in        = top_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      map_req       = '{we: 1'b0, waddr: word_ff, wdata: res_word, raddr: word_ff};
      sum_req       = '{we: 1'b0, waddr: word_sidx, wdata: sum_new, raddr: word_sidx};

      case (state_ff)
         pba_pkg::S_CLEAR: begin
            map_req.we    = 1'b1;
            map_req.waddr = clr_ff;
            map_req.wdata = '0;
            sum_req.we    = 32'(clr_ff) < 32'(pba_pkg::SUM_WORDS);
            sum_req.waddr = pba_pkg::sum_idx_type'(clr_ff);
            sum_req.wdata = pad_word;
            clr_in        = clr_ff + pba_pkg::word_idx_type'(1);
            if (clr_ff == pba_pkg::word_idx_type'(pba_pkg::MAP_WORDS - 1)) begin
               state_in = pba_pkg::S_IDLE;
            end
         end

         pba_pkg::S_IDLE: begin
            if (start) begin
               op_in         = req_opcode;
               rsp_status_in = pba_pkg::ST_OK;
               rsp_addr_in   = '0;
               case (req_opcode)
                  pba_pkg::OP_RESERVE: begin
                     if (req_length == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = pba_pkg::ST_ZERO_LEN;
                     end else if (!in_map) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        word_in       = first_span[pba_pkg::FRAME_W-1:pba_pkg::BIT_W];
                        lo_in         = first_span[pba_pkg::BIT_W-1:0];
                        last_word_in  = last_span[pba_pkg::FRAME_W-1:pba_pkg::BIT_W];
                        last_bit_in   = last_span[pba_pkg::BIT_W-1:0];
                        map_req.raddr = first_span[pba_pkg::FRAME_W-1:pba_pkg::BIT_W];
                        state_in      = pba_pkg::S_RES_MOD;
                     end
                  end
                  pba_pkg::OP_ALLOC: begin
                     if (!top_hit) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = pba_pkg::ST_FULL;
                     end else begin
                        sidx_in       = top_idx;
                        sum_req.raddr = top_idx;
                        state_in      = pba_pkg::S_ALC_SUM;
                     end
                  end
                  pba_pkg::OP_RELEASE: begin
                     if (!in_map) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        word_in       = first_span[pba_pkg::FRAME_W-1:pba_pkg::BIT_W];
                        lo_in         = first_span[pba_pkg::BIT_W-1:0];
                        map_req.raddr = first_span[pba_pkg::FRAME_W-1:pba_pkg::BIT_W];
                        state_in      = pba_pkg::S_REL_MOD;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         pba_pkg::S_RES_MOD: begin
            map_req.we    = 1'b1;
            map_req.wdata = res_word;
            if (&res_word) begin
               set_in   = 1'b1;
               state_in = pba_pkg::S_SUM_UPD;
            end else if (word_ff == last_word_ff) begin
               rsp_valid_in = 1'b1;
               state_in     = pba_pkg::S_IDLE;
            end else begin
               // advance to the next word, data arrives next cycle
               word_in       = word_next;
               lo_in         = '0;
               map_req.raddr = word_next;
            end
         end

         pba_pkg::S_ALC_SUM: begin
            word_in       = pba_pkg::word_idx_type'({sidx_ff, pba_pkg::first_zero(sum_rdata)});
            map_req.raddr = pba_pkg::word_idx_type'({sidx_ff, pba_pkg::first_zero(sum_rdata)});
            state_in      = pba_pkg::S_ALC_MAP;
         end

         pba_pkg::S_ALC_MAP: begin
            if (alc_over) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pba_pkg::ST_LIMIT;
               state_in      = pba_pkg::S_IDLE;
            end else begin
               map_req.we    = 1'b1;
               map_req.wdata = alc_word;
               rsp_addr_in   = pba_pkg::addr_type'(alc_faddr);
               if (&alc_word) begin
                  set_in   = 1'b1;
                  state_in = pba_pkg::S_SUM_UPD;
               end else begin
                  rsp_valid_in = 1'b1;
                  state_in     = pba_pkg::S_IDLE;
               end
            end
         end

         pba_pkg::S_REL_MOD: begin
            map_req.we    = 1'b1;
            map_req.wdata = rel_word;
            if (&map_rdata) begin
               set_in   = 1'b0;
               state_in = pba_pkg::S_SUM_UPD;
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = pba_pkg::S_IDLE;
            end
         end

         pba_pkg::S_SUM_UPD: begin
            sum_req.we        = 1'b1;
            top_in[word_sidx] = &sum_new;
            if (op_ff == pba_pkg::OP_RESERVE && word_ff != last_word_ff) begin
               word_in       = word_next;
               lo_in         = '0;
               map_req.raddr = word_next;
               state_in      = pba_pkg::S_RES_MOD;
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = pba_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = pba_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pba_pkg::S_CLEAR;
         clr_ff       <= '0;
         top_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         top_ff       <= top_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff       <= word_in;
      lo_ff         <= lo_in;
      last_word_ff  <= last_word_in;
      last_bit_ff   <= last_bit_in;
      sidx_ff       <= sidx_in;
      op_ff         <= op_in;
      set_ff        <= set_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
   end

   assign busy              = (state_ff != pba_pkg::S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_frame_address = rsp_addr_ff;

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pba_pkg::S_IDLE) |-> (!map_req.we && !sum_req.we))
      else $error("memory write while idle");

   a_clear_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pba_pkg::S_CLEAR) |-> !rsp_valid_ff)
      else $error("result during clearing pass");

   a_err_zero_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != pba_pkg::ST_OK) |-> (rsp_addr_ff == '0))
      else $error("error result carries an address");

   a_accept_moves: assert property (@(posedge clock) disable iff (reset)
      (start && state_ff == pba_pkg::S_IDLE) |=> (busy || rsp_valid_ff))
      else $error("accepted request neither started nor answered");

   a_alloc_word_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pba_pkg::S_ALC_MAP) |-> !(&map_rdata))
      else $error("summary map points at a full word");

endmodule
